>>> sv/cprf_pkg.sv
`default_nettype none
// ============================================================================
// cprf_pkg
// Types and constants shared by the chunked program receiver.
// ============================================================================
package cprf_pkg;

    localparam int SIZE_W = 25;
    localparam int ADDR_W = 24;
    localparam int LEN_W  = 12;
    localparam int KIND_W = 4;

    localparam logic [63:0]       FNV_BASIS      = 64'hCBF29CE484222325;
    localparam logic [LEN_W-1:0]  INFO_LEN       = 12'd24;
    localparam logic [SIZE_W-1:0] MAX_SIZE_RST   = 25'd16777216;
    localparam logic [KIND_W-1:0] START_CODE_RST = 4'd1;
    localparam logic [KIND_W-1:0] CHUNK_CODE_RST = 4'd2;
    localparam logic [KIND_W-1:0] STOP_CODE_RST  = 4'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_INFO,
        PH_CHUNK_WAIT,
        PH_CHUNK_DATA,
        PH_STOP_WAIT
    } t_phase;

    typedef enum logic [1:0] {
        ST_BUSY,
        ST_OK,
        ST_ABORT,
        ST_BADSUM
    } t_status;

    typedef enum logic [1:0] {
        CFG_MAX_SIZE,
        CFG_START_CODE,
        CFG_CHUNK_CODE,
        CFG_STOP_CODE
    } t_cfg_idx;

    typedef struct packed {
        logic              we;
        t_cfg_idx          addr;
        logic [SIZE_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic              command;
        logic [KIND_W-1:0] message_kind;
        logic [LEN_W-1:0]  message_length;
        logic [7:0]        data_byte;
    } t_item;

    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        write_byte;
        t_status           status;
        logic [SIZE_W-1:0] received_size;
    } t_result;

endpackage
`default_nettype wire

>>> sv/cprf_if.sv
`default_nettype none
// ============================================================================
// cprf_in_if / cprf_out_if
// Valid/ready channels for message items and for results.
// ============================================================================
interface cprf_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [3:0]  message_kind;
    logic [11:0] message_length;
    logic [7:0]  data_byte;

    modport source (output valid, command, message_kind, message_length, data_byte,
                    input ready);
    modport sink   (input valid, command, message_kind, message_length, data_byte,
                    output ready);
endinterface

interface cprf_out_if;
    logic        valid;
    logic        ready;
    logic        write_valid;
    logic [23:0] write_address;
    logic [7:0]  write_byte;
    logic [1:0]  status;
    logic [24:0] received_size;

    modport source (output valid, write_valid, write_address, write_byte, status,
                    received_size, input ready);
    modport sink   (input valid, write_valid, write_address, write_byte, status,
                    received_size, output ready);
endinterface
`default_nettype wire

>>> sv/cprf_skid.sv
`default_nettype none
// ============================================================================
// cprf_skid
// Two-entry result buffer with a registered ready toward the core.
// ============================================================================
module cprf_skid
    import cprf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_result i_data,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    w_take;
    logic    w_load;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign w_take  = r_main_valid && i_ready;
    assign w_load  = i_valid && !r_skid_valid;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (w_load) begin
            if (!r_main_valid || w_take) begin
                n_main       = i_data;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (w_take) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_main_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule
`default_nettype wire

>>> sv/cprf_core.sv
`default_nettype none
// ============================================================================
// cprf_core
// Transfer state, configuration registers and per-beat result logic.
// ============================================================================
module cprf_core
    import cprf_pkg::*;
#(
    parameter int ADDR_BITS = 24
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg_wr i_cfg,
    input  wire logic    i_fire,
    input  wire t_item   i_item,
    output t_result      o_result
);

    localparam int ADDR_KEEP = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam logic [ADDR_W-1:0] ADDR_MASK =
        ADDR_W'((ADDR_W+1)'(1) << ADDR_KEEP) - ADDR_W'(1);

    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

    logic [SIZE_W-1:0] r_max_size;
    logic [KIND_W-1:0] r_start_code;
    logic [KIND_W-1:0] r_chunk_code;
    logic [KIND_W-1:0] r_stop_code;

    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_bytes_left, n_bytes_left;
    logic [4:0]        r_info_idx, n_info_idx;
    logic [63:0]       r_total, n_total;
    logic [63:0]       r_chunks, n_chunks;
    logic [63:0]       r_exp_hash, n_exp_hash;
    logic [63:0]       r_hash, n_hash;
    logic [SIZE_W-1:0] r_offset, n_offset;

    logic [63:0]      w_byte_sh;
    logic [63:0]      w_total_upd;
    logic [63:0]      w_chunks_upd;
    logic [63:0]      w_exp_upd;
    logic [63:0]      w_chunks_dec;
    logic [LEN_W-1:0] w_bytes_dec;
    logic             w_overrun;
    logic             w_total_big;
    logic             w_left;

    assign w_byte_sh    = {56'd0, i_item.data_byte} << {r_info_idx[2:0], 3'b000};
    assign w_total_upd  = (r_info_idx[4:3] == 2'd0) ? (r_total | w_byte_sh) : r_total;
    assign w_chunks_upd = (r_info_idx[4:3] == 2'd1) ? (r_chunks | w_byte_sh) : r_chunks;
    assign w_exp_upd    = (r_info_idx[4] == 1'b1) ? (r_exp_hash | w_byte_sh) : r_exp_hash;
    assign w_chunks_dec = r_chunks - 64'd1;
    assign w_bytes_dec  = r_bytes_left - LEN_W'(1);
    assign w_overrun    = ({39'd0, r_offset} + {52'd0, i_item.message_length}) > r_total;
    assign w_total_big  = w_total_upd > {39'd0, r_max_size};
    assign w_left       = (r_bytes_left != '0);

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_info_idx   = r_info_idx;
        n_total      = r_total;
        n_chunks     = r_chunks;
        n_exp_hash   = r_exp_hash;
        n_hash       = r_hash;
        n_offset     = r_offset;
        if (i_fire) begin
            if (!i_item.command) begin
                if (r_phase == PH_IDLE) begin
                    if (i_item.message_kind == r_start_code &&
                        i_item.message_length == INFO_LEN) begin
                        n_phase      = PH_INFO;
                        n_bytes_left = i_item.message_length;
                        n_info_idx   = '0;
                        n_total      = '0;
                        n_chunks     = '0;
                        n_exp_hash   = '0;
                        n_hash       = FNV_BASIS;
                        n_offset     = '0;
                    end
                end else if (w_left) begin
                    n_phase = PH_IDLE;
                end else if (r_phase == PH_CHUNK_WAIT) begin
                    if (i_item.message_kind != r_chunk_code || w_overrun) begin
                        n_phase = PH_IDLE;
                    end else if (i_item.message_length == '0) begin
                        n_chunks = w_chunks_dec;
                        n_phase  = (w_chunks_dec == '0) ? PH_STOP_WAIT : PH_CHUNK_WAIT;
                    end else begin
                        n_bytes_left = i_item.message_length;
                        n_phase      = PH_CHUNK_DATA;
                    end
                end else begin
                    n_phase = PH_IDLE;
                end
                if (n_phase == PH_IDLE) begin
                    n_bytes_left = '0;
                end
            end else if (r_phase == PH_INFO && w_left) begin
                n_total      = w_total_upd;
                n_chunks     = w_chunks_upd;
                n_exp_hash   = w_exp_upd;
                n_info_idx   = r_info_idx + 5'd1;
                n_bytes_left = w_bytes_dec;
                if (w_bytes_dec == '0) begin
                    if (w_total_big) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = (w_chunks_upd == '0) ? PH_STOP_WAIT : PH_CHUNK_WAIT;
                    end
                end
            end else if (r_phase == PH_CHUNK_DATA && w_left) begin
                n_hash       = fnv_step(r_hash, i_item.data_byte);
                n_offset     = r_offset + SIZE_W'(1);
                n_bytes_left = w_bytes_dec;
                if (w_bytes_dec == '0) begin
                    n_chunks = w_chunks_dec;
                    n_phase  = (w_chunks_dec == '0) ? PH_STOP_WAIT : PH_CHUNK_WAIT;
                end
            end
        end
    end

    always_comb begin
        o_result = '0;
        if (!i_item.command) begin
            if (r_phase == PH_IDLE) begin
                if (i_item.message_kind == r_start_code &&
                    i_item.message_length != INFO_LEN) begin
                    o_result.status = ST_ABORT;
                end
            end else if (w_left) begin
                o_result.status = ST_ABORT;
            end else if (r_phase == PH_CHUNK_WAIT) begin
                if (i_item.message_kind != r_chunk_code || w_overrun) begin
                    o_result.status = ST_ABORT;
                end
            end else if (r_phase == PH_STOP_WAIT) begin
                if (i_item.message_kind != r_stop_code) begin
                    o_result.status = ST_ABORT;
                end else begin
                    o_result.received_size = r_offset;
                    o_result.status        = (r_hash == r_exp_hash) ? ST_OK : ST_BADSUM;
                end
            end else begin
                o_result.status = ST_ABORT;
            end
        end else if (r_phase == PH_INFO && w_left) begin
            if (w_bytes_dec == '0 && w_total_big) begin
                o_result.status = ST_ABORT;
            end
        end else if (r_phase == PH_CHUNK_DATA && w_left) begin
            o_result.write_valid   = 1'b1;
            o_result.write_address = r_offset[ADDR_W-1:0] & ADDR_MASK;
            o_result.write_byte    = i_item.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size   <= MAX_SIZE_RST;
            r_start_code <= START_CODE_RST;
            r_chunk_code <= CHUNK_CODE_RST;
            r_stop_code  <= STOP_CODE_RST;
            r_phase      <= PH_IDLE;
            r_bytes_left <= '0;
            r_info_idx   <= '0;
            r_total      <= '0;
            r_chunks     <= '0;
            r_exp_hash   <= '0;
            r_hash       <= FNV_BASIS;
            r_offset     <= '0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.addr)
                    CFG_MAX_SIZE:   r_max_size   <= i_cfg.data;
                    CFG_START_CODE: r_start_code <= i_cfg.data[KIND_W-1:0];
                    CFG_CHUNK_CODE: r_chunk_code <= i_cfg.data[KIND_W-1:0];
                    CFG_STOP_CODE:  r_stop_code  <= i_cfg.data[KIND_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_info_idx   <= n_info_idx;
            r_total      <= n_total;
            r_chunks     <= n_chunks;
            r_exp_hash   <= n_exp_hash;
            r_hash       <= n_hash;
            r_offset     <= n_offset;
        end
    end

`ifndef SYNTHESIS
    a_idle_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_bytes_left == '0)
        else $error("bytes pending while idle");

    a_offset_in_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CHUNK_WAIT || r_phase == PH_CHUNK_DATA || r_phase == PH_STOP_WAIT)
        |-> {39'd0, r_offset} <= r_total)
        else $error("write offset beyond announced total");

    a_write_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.write_valid |=> r_offset == $past(r_offset) + SIZE_W'(1))
        else $error("write offset did not advance after a stored byte");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.write_valid |-> o_result.status == ST_BUSY &&
        o_result.received_size == '0)
        else $error("stored byte carries a final status");
`endif

endmodule
`default_nettype wire

>>> sv/chunked_program_receiver_fnv.sv
`default_nettype none
// ============================================================================
// chunked_program_receiver_fnv
// Receives a chunked program transfer, emits byte writes and checks the
// FNV-1a-64 hash of the received data against the announced one.
//
//   Channel  Dir  Handshake      Payload
//   i_req    in   valid/ready    command, message_kind, message_length, data_byte
//   o_rsp    out  valid/ready    write_valid, write_address, write_byte, status,
//                                received_size
//   i_cfg_*  in   write enable   register index, write data
//
// Every beat yields one result, which is registered in the output buffer.
// One beat can be accepted in every cycle while i_req.ready is high; the hash
// update and all state changes complete in the accepting cycle.
// A two-entry output buffer keeps i_req.ready registered; it drops only while
// two results wait for o_rsp.
// Synchronous reset clears the transfer state and restores register defaults.
// ============================================================================
module chunked_program_receiver_fnv
    import cprf_pkg::*;
#(
    parameter int ADDR_BITS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    cprf_in_if.sink          i_req,
    cprf_out_if.source       o_rsp,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [24:0] i_cfg_data
);

    t_cfg_wr w_cfg;
    t_item   w_item;
    t_result w_result;
    t_result w_out;
    logic    w_fire;
    logic    w_ready;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.addr = t_cfg_idx'(i_cfg_addr);
    assign w_cfg.data = i_cfg_data;

    assign w_item.command        = i_req.command;
    assign w_item.message_kind   = i_req.message_kind;
    assign w_item.message_length = i_req.message_length;
    assign w_item.data_byte      = i_req.data_byte;

    assign i_req.ready = w_ready;
    assign w_fire      = i_req.valid && w_ready;

    cprf_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_fire   (w_fire),
        .i_item   (w_item),
        .o_result (w_result)
    );

    cprf_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fire),
        .o_ready (w_ready),
        .i_data  (w_result),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_data  (w_out)
    );

    assign o_rsp.write_valid   = w_out.write_valid;
    assign o_rsp.write_address = w_out.write_address;
    assign o_rsp.write_byte    = w_out.write_byte;
    assign o_rsp.status        = w_out.status;
    assign o_rsp.received_size = w_out.received_size;

endmodule
`default_nettype wire
